// ===== rtl/cbpg_pkg.sv =====
// Shared types and constants of the cubic Bezier point generator.
// No dependencies; imported by cubic_bezier_point_generator and cbpg_checker.
package cbpg_pkg;

	// Configuration register: number of t intervals per curve
	localparam int SEG_BITS = 6;
	localparam logic [SEG_BITS-1:0] SEG_RESET = 6'd10;

	// Curve geometry: four control points, three axes each
	localparam int N_PTS    = 4;
	localparam int N_AXES   = 3;
	localparam int N_FIELDS = N_PTS * N_AXES;

	// Axis counter and Horner step counter
	localparam logic [1:0] AXIS_LAST = 2'd2;
	localparam logic [1:0] STEP_B    = 2'd0;
	localparam logic [1:0] STEP_C    = 2'd1;
	localparam logic [1:0] STEP_D    = 2'd2;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIV  = 9'b000000010,
		ST_LOAD = 9'b000000100,
		ST_MLO  = 9'b000001000,
		ST_MHI  = 9'b000010000,
		ST_SUM  = 9'b000100000,
		ST_ADDK = 9'b001000000,
		ST_RND  = 9'b010000000,
		ST_EMIT = 9'b100000000
	} state_t;

endpackage

// ===== rtl/cubic_bezier_point_generator.sv =====
// Cubic Bezier point generator: one curve in, segments+1 curve points out.
// Depends on cbpg_pkg (state type, register and geometry constants).
//
// Channel   Dir  Handshake                  Payload
// config    in   seg_wr_en                  seg_wr_data: segments (0 acts as 1)
// curve     in   s_tvalid / s_tready        s_tdata: 12 control coordinates
// point     out  m_tvalid / m_tready        m_tdata: x, y, z; m_tlast: t = 1
//
// Steps: a curve first passes the bit-serial reciprocal divider; each point
// then takes, per axis, a load, three Horner steps (multiply low half,
// multiply high half, sum, add coefficient) and a round, and is then
// emitted; one shared HW x (T_FRAC_BITS+1) multiplier is used twice per
// Horner step. A new curve is accepted only once the last point of the one
// before has been emitted.
// Reset (arst_n low) returns the sequencer to idle, drops any pending point
// and restores segments to 10. A stalled point beat holds in the output
// register while the next point is computed; only the hand-over waits.
module cubic_bezier_point_generator #(
	parameter int COORD_BITS  = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             seg_wr_en,
	input  logic [cbpg_pkg::SEG_BITS-1:0]                    seg_wr_data,
	input  logic                                             s_tvalid,
	output logic                                             s_tready,
	// s_tdata, from bit 0 up: ctrl0_x, ctrl0_y, ctrl0_z, ctrl1_x, ctrl1_y,
	// ctrl1_z, ctrl2_x, ctrl2_y, ctrl2_z, ctrl3_x, ctrl3_y, ctrl3_z, zero pad
	input  logic [((cbpg_pkg::N_FIELDS*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                             m_tvalid,
	input  logic                                             m_tready,
	// m_tdata, from bit 0 up: point_x, point_y, point_z, zero pad
	output logic [((cbpg_pkg::N_AXES*COORD_BITS+7)/8)*8-1:0]   m_tdata,
	// m_tlast: last_point
	output logic                                             m_tlast
);
	import cbpg_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int F     = T_FRAC_BITS;
	localparam int OUT_W = ((N_AXES * C + 7) / 8) * 8;
	localparam int KW    = C + 4;            // coefficient width, signed
	localparam int H     = C + F + 6;        // Horner accumulator, signed
	localparam int MW    = H - 1;            // accumulator magnitude
	localparam int HW    = (MW + 1) / 2;     // magnitude half fed to the multiplier
	localparam int PW    = HW + F + 1;       // one partial product
	localparam int FW    = MW + F + 1;       // full product
	localparam int RW    = MW + 1 - F;       // rounded integer magnitude
	localparam int EXT   = H - KW - F;       // sign bits above a scaled coefficient
	localparam int DCW   = $clog2(F + 1);

	localparam logic [F:0]    T_ONE  = (F + 1)'(1) << F;
	localparam logic [FW-1:0] HALF_P = FW'(1) << (F - 1);
	localparam logic [MW:0]   HALF_M = (MW + 1)'(1) << (F - 1);
	localparam logic [RW-1:0] LIM    = RW'(1) << (C - 1);

	// Control state
	state_t                state_q;
	logic [SEG_BITS-1:0]   seg_cfg_q;
	logic [DCW-1:0]        dcnt_q;
	logic [1:0]            step_q;
	logic [1:0]            ax_q;
	logic [SEG_BITS-1:0]   idx_q;
	logic                  m_tvalid_q;

	// Curve and datapath registers
	logic [SEG_BITS-1:0]   seg_q;
	logic signed [KW-1:0]  a_q [N_AXES];
	logic signed [KW-1:0]  b_q [N_AXES];
	logic signed [KW-1:0]  c_q [N_AXES];
	logic signed [C-1:0]   d_q [N_AXES];
	logic [SEG_BITS-1:0]   rem_q;      // 2^F mod segments
	logic [F:0]            quo_q;      // 2^F div segments
	logic [F:0]            t_q;
	logic [SEG_BITS-1:0]   tr_q;       // remainder of the t numerator
	logic signed [H-1:0]   h_q;
	logic [PW-1:0]         p_q;
	logic [PW-1:0]         lo_q;
	logic [MW-1:0]         r_q;
	logic [C-1:0]          pt_q [N_AXES];
	logic [C-1:0]          out_pt_q [N_AXES];
	logic                  out_last_q;

	// Combinational
	logic                  in_acc;
	logic                  emit_go;
	logic                  pt_last;
	logic [SEG_BITS-1:0]   seg_eff;
	logic signed [C-1:0]   pin [N_PTS][N_AXES];
	logic signed [KW-1:0]  a_n [N_AXES];
	logic signed [KW-1:0]  b_n [N_AXES];
	logic signed [KW-1:0]  c_n [N_AXES];
	logic [SEG_BITS:0]     div_sh;
	logic                  div_ge;
	logic [SEG_BITS-1:0]   div_rem_n;
	logic [SEG_BITS:0]     tr_sum;
	logic                  tr_ge;
	logic [H-1:0]          h_abs;
	logic [MW-1:0]         mag;
	logic [2*HW-1:0]       mag_ext;
	logic [HW-1:0]         mul_a;
	logic [PW-1:0]         prod;
	logic [FW-1:0]         sum_f;
	logic signed [H-1:0]   a_ext;
	logic signed [H-1:0]   h_add;
	logic [MW:0]           rsum;
	logic [RW-1:0]         rr;
	logic [C-1:0]          rnd_val;
	logic [F+7:0]          div_chk;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign emit_go  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign pt_last  = (idx_q == seg_q);
	assign seg_eff  = (seg_cfg_q == '0) ? SEG_BITS'(1) : seg_cfg_q;

	// Unpack the control points and form the power-basis coefficients per axis
	always_comb begin
		logic signed [KW-1:0] e10, e21, e32;
		for (int j = 0; j < N_PTS; j++) begin
			for (int ax = 0; ax < N_AXES; ax++) begin
				pin[j][ax] = s_tdata[(N_AXES * j + ax) * C +: C];
			end
		end
		for (int ax = 0; ax < N_AXES; ax++) begin
			e10 = KW'(pin[1][ax]) - KW'(pin[0][ax]);
			e21 = KW'(pin[2][ax]) - KW'(pin[1][ax]);
			e32 = KW'(pin[3][ax]) - KW'(pin[2][ax]);
			c_n[ax] = (e10 <<< 1) + e10;
			b_n[ax] = ((e21 - e10) <<< 1) + (e21 - e10);
			a_n[ax] = e32 - (e21 <<< 1) + e10;
		end
	end

	// Restoring divider step for 2^F / segments: the dividend has one set bit
	always_comb begin
		div_sh    = {rem_q, (dcnt_q == '0)};
		div_ge    = (div_sh >= {1'b0, seg_q});
		div_rem_n = div_ge ? SEG_BITS'(div_sh - {1'b0, seg_q}) : div_sh[SEG_BITS-1:0];
	end

	// Next t: add the quotient, carry one when the remainder wraps
	always_comb begin
		tr_sum = {1'b0, tr_q} + {1'b0, rem_q};
		tr_ge  = (tr_sum >= {1'b0, seg_q});
	end

	// Shared multiplier: magnitude halves times t
	always_comb begin
		h_abs   = h_q[H-1] ? (~h_q + 1'b1) : h_q;
		mag     = h_abs[MW-1:0];
		mag_ext = (2 * HW)'(mag);
		mul_a   = (state_q == ST_MHI) ? mag_ext[2*HW-1:HW] : mag_ext[HW-1:0];
		prod    = {{(F + 1){1'b0}}, mul_a} * {{HW{1'b0}}, t_q};
		sum_f   = FW'(lo_q) + FW'({p_q, {HW{1'b0}}}) + HALF_P;
	end

	// Horner accumulate: restore the sign, add the next scaled coefficient
	always_comb begin
		logic signed [KW-1:0] ka;
		logic signed [KW-1:0] kk;
		logic signed [H-1:0]  rs;
		ka    = a_q[ax_q];
		a_ext = {{EXT{ka[KW-1]}}, ka, {F{1'b0}}};
		case (step_q)
			STEP_B:  kk = b_q[ax_q];
			STEP_C:  kk = c_q[ax_q];
			default: kk = KW'(d_q[ax_q]);
		endcase
		rs    = {1'b0, r_q};
		if (h_q[H-1]) begin
			rs = -rs;
		end
		h_add = rs + {{EXT{kk[KW-1]}}, kk, {F{1'b0}}};
	end

	// Final rounding to an integer coordinate with saturation
	always_comb begin
		rsum = {1'b0, mag} + HALF_M;
		rr   = rsum[MW:F];
		if (!h_q[H-1]) begin
			rnd_val = (rr > (LIM - 1'b1)) ? {1'b0, {(C - 1){1'b1}}} : rr[C-1:0];
		end else begin
			rnd_val = (rr > LIM) ? {1'b1, {(C - 1){1'b0}}} : (~rr[C-1:0] + 1'b1);
		end
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seg_cfg_q  <= SEG_RESET;
			dcnt_q     <= '0;
			step_q     <= STEP_B;
			ax_q       <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (seg_wr_en) begin
				seg_cfg_q <= seg_wr_data;
			end
			// raise valid on a new point, drop the beat once taken
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dcnt_q == DCW'(F)) begin
						ax_q    <= '0;
						idx_q   <= '0;
						state_q <= ST_LOAD;
					end else begin
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				ST_LOAD: begin
					step_q  <= STEP_B;
					state_q <= ST_MLO;
				end
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ADDK;
				ST_ADDK: begin
					if (step_q == STEP_D) begin
						state_q <= ST_RND;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_MLO;
					end
				end
				ST_RND: begin
					if (ax_q == AXIS_LAST) begin
						state_q <= ST_EMIT;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (pt_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							ax_q    <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					for (int ax = 0; ax < N_AXES; ax++) begin
						a_q[ax] <= a_n[ax];
						b_q[ax] <= b_n[ax];
						c_q[ax] <= c_n[ax];
						d_q[ax] <= pin[0][ax];
					end
					seg_q <= seg_eff;
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= div_rem_n;
				quo_q <= {quo_q[F-1:0], div_ge};
				if (dcnt_q == DCW'(F)) begin
					t_q  <= '0;
					tr_q <= seg_q >> 1;
				end
			end
			ST_LOAD: h_q <= a_ext;
			ST_MLO:  p_q <= prod;
			ST_MHI: begin
				lo_q <= p_q;
				p_q  <= prod;
			end
			ST_SUM:  r_q <= sum_f[F+MW-1:F];
			ST_ADDK: h_q <= h_add;
			ST_RND:  pt_q[ax_q] <= rnd_val;
			ST_EMIT: begin
				if (emit_go) begin
					for (int ax = 0; ax < N_AXES; ax++) begin
						out_pt_q[ax] <= pt_q[ax];
					end
					out_last_q <= pt_last;
					if (!pt_last) begin
						tr_q <= tr_ge ? SEG_BITS'(tr_sum - {1'b0, seg_q})
						              : tr_sum[SEG_BITS-1:0];
						t_q  <= t_q + quo_q + (F + 1)'(tr_ge);
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_W'({out_pt_q[2], out_pt_q[1], out_pt_q[0]});

	assign div_chk = (F + 8)'(quo_q) * (F + 8)'(seg_q) + (F + 8)'(rem_q);

	// The reciprocal must reproduce 2^F exactly while points are produced
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != ST_IDLE) && (state_q != ST_DIV)) |-> (div_chk == ((F + 8)'(1) << F)))
		else $error("reciprocal of segments inconsistent");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != ST_IDLE) && (state_q != ST_DIV)) |-> ((t_q <= T_ONE) && (tr_q < seg_q)))
		else $error("t or its remainder out of range");

	a_t_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && pt_last) |-> (t_q == T_ONE))
		else $error("last point not at t = 1");

	a_t_start: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD) && (idx_q == '0)) |-> (t_q == '0))
		else $error("first point not at t = 0");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> ((state_q == ST_DIV) && (dcnt_q == '0)))
		else $error("accepted curve did not start the divider");

endmodule

// ===== bench/cbpg_checker.sv =====
// Scoreboard for cubic_bezier_point_generator: watches the config, curve and point channels,
// predicts every curve point in fixed point and compares each point beat field by field.
// Depends on cbpg_pkg for the register width, its reset value and the curve geometry.
module cbpg_checker #(
	parameter int COORD_W = 16,
	parameter int CURVE_W = ((cbpg_pkg::N_FIELDS * COORD_W + 7) / 8) * 8,
	parameter int POINT_W = ((cbpg_pkg::N_AXES * COORD_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          seg_wr_en,
	input  logic [cbpg_pkg::SEG_BITS-1:0] seg_wr_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [CURVE_W-1:0]            s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [POINT_W-1:0]            m_tdata,
	input  logic                          m_tlast,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cbpg_pkg::*;

	localparam int     T_FRAC = 16;
	localparam longint T_ONE  = longint'(1) << T_FRAC;
	localparam longint T_HALF = longint'(1) << (T_FRAC - 1);
	localparam longint C_MAX  = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint C_MIN  = -C_MAX - 1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               is_last;
	} curve_point_t;

	curve_point_t        expected_points[$];
	logic [SEG_BITS-1:0] seg_count;
	int                  mismatches = 0;

	// round(h * t / 2^F), ties away from zero
	function automatic longint scale_by_t(longint h, longint t);
		longint mag;
		mag = (h < 0) ? -h : h;
		mag = (mag * t + T_HALF) >>> T_FRAC;
		return (h < 0) ? -mag : mag;
	endfunction

	// Horner evaluation of one axis at parameter t (Q1.16, 0 to 1), rounded and clamped
	function automatic logic [COORD_W-1:0] eval_coord(longint p0, longint p1, longint p2,
			longint p3, longint t);
		longint a, b, c, h, mag, v;
		a = p3 - 3 * p2 + 3 * p1 - p0;
		b = 3 * (p2 - 2 * p1 + p0);
		c = 3 * (p1 - p0);
		h = a * T_ONE;
		h = scale_by_t(h, t) + b * T_ONE;
		h = scale_by_t(h, t) + c * T_ONE;
		h = scale_by_t(h, t) + p0 * T_ONE;
		mag = (h < 0) ? -h : h;
		mag = (mag + T_HALF) >>> T_FRAC;
		v = (h < 0) ? -mag : mag;
		if (v > C_MAX) v = C_MAX;
		if (v < C_MIN) v = C_MIN;
		return v[COORD_W-1:0];
	endfunction

	// Queue the segments+1 points of one accepted curve, t rising
	function automatic void queue_curve_points(logic [CURVE_W-1:0] ctrl);
		longint       p [N_FIELDS];
		longint       span, t;
		curve_point_t pt;
		for (int k = 0; k < N_FIELDS; k++)
			p[k] = longint'($signed(ctrl[COORD_W*k +: COORD_W]));
		span = (seg_count == 0) ? 64'sd1 : longint'(seg_count);
		for (longint i = 0; i <= span; i++) begin
			t = ((i <<< T_FRAC) + span / 2) / span;
			pt.x = eval_coord(p[0], p[3], p[6], p[9], t);
			pt.y = eval_coord(p[1], p[4], p[7], p[10], t);
			pt.z = eval_coord(p[2], p[5], p[8], p[11], t);
			pt.is_last = (i == span);
			expected_points.insert(expected_points.size(), pt);
		end
	endfunction

	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: point mismatch: %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track_points
		curve_point_t want;
		logic [COORD_W-1:0] got_x, got_y, got_z;
		if (!arst_n) begin
			seg_count = SEG_RESET;
			expected_points.delete();
		end else begin
			if (seg_wr_en)
				seg_count = seg_wr_data;
			if (s_tvalid && s_tready)
				queue_curve_points(s_tdata);
			if (m_tvalid && m_tready) begin
				got_x = m_tdata[0 +: COORD_W];
				got_y = m_tdata[COORD_W +: COORD_W];
				got_z = m_tdata[2*COORD_W +: COORD_W];
				if (expected_points.size() == 0) begin
					note_mismatch($sformatf("unexpected beat x=%0d y=%0d z=%0d last=%0b",
						$signed(got_x), $signed(got_y), $signed(got_z), m_tlast));
				end else begin
					want = expected_points.pop_front();
					if (got_x !== want.x || got_y !== want.y || got_z !== want.z ||
							m_tlast !== want.is_last)
						note_mismatch($sformatf(
							"expected x=%0d y=%0d z=%0d last=%0b, got x=%0d y=%0d z=%0d last=%0b",
							$signed(want.x), $signed(want.y), $signed(want.z), want.is_last,
							$signed(got_x), $signed(got_y), $signed(got_z), m_tlast));
				end
			end
		end
		pending    <= expected_points.size();
		fail_count <= mismatches;
	end

endmodule

// ===== bench/cubic_bezier_point_generator_tb.sv =====
// Top-level testbench for cubic_bezier_point_generator: drives curves, segment counts and
// point back-pressure, and gives the verdict. Depends on cbpg_pkg and cbpg_checker.
module cubic_bezier_point_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W     = 16;
	localparam int CURVE_W     = ((cbpg_pkg::N_FIELDS * COORD_W + 7) / 8) * 8;
	localparam int POINT_W     = ((cbpg_pkg::N_AXES * COORD_W + 7) / 8) * 8;
	localparam int HOLD_CYCLES = 3000;   // long receiver hold-off, fills the block
	localparam int TAIL_CYCLES = 20;     // quiet time after the last point beat
	localparam int CHUNK_ITEMS = 7;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          seg_wr_en   = 1'b0;
	logic [cbpg_pkg::SEG_BITS-1:0] seg_wr_data = '0;
	logic                          s_tvalid    = 1'b0;
	logic [CURVE_W-1:0]            s_tdata     = '0;
	logic                          m_tready    = 1'b0;
	logic                          s_tready;
	logic                          m_tvalid;
	logic [POINT_W-1:0]            m_tdata;
	logic                          m_tlast;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off_req  = 1'b0;

	cubic_bezier_point_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.seg_wr_en   (seg_wr_en),
		.seg_wr_data (seg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	cbpg_checker #(.COORD_W(COORD_W)) point_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.seg_wr_en   (seg_wr_en),
		.seg_wr_data (seg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs; the slowest legal run is far shorter
	initial begin
		#20_000_000;
		$display("cubic_bezier_point_generator regression: fail");
		$finish;
	end

	// Point sink: random back-pressure, plus one long hold-off on request so that
	// the output register stays full and the curve input stalls behind it
	initial begin : point_sink
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Offer one curve beat and hold it until accepted; may idle first.
	// Returns at the edge that took the beat, with s_tvalid still high.
	task automatic send_curve(input logic [CURVE_W-1:0] curve);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= curve;
		do @(posedge clk); while (!s_tready);
	endtask

	// Directed curve: x follows the four given values, y their bitwise inverse
	// (so the opposite extreme), z is random
	task automatic send_pattern(input logic [15:0] v0, v1, v2, v3);
		logic [CURVE_W-1:0] curve;
		logic [15:0]        vals [4];
		vals  = '{v0, v1, v2, v3};
		curve = '0;
		for (int n = 0; n < cbpg_pkg::N_PTS; n++) begin
			curve[48*n +: 16]      = vals[n];
			curve[48*n + 16 +: 16] = ~vals[n];
			curve[48*n + 32 +: 16] = 16'($urandom);
		end
		send_curve(curve);
	endtask

	// Random curve; a share of coordinates sits next to the rails to provoke
	// rounding past the coordinate range
	function automatic logic [CURVE_W-1:0] random_curve();
		logic [CURVE_W-1:0] curve;
		curve = '0;
		for (int k = 0; k < cbpg_pkg::N_FIELDS; k++) begin
			case ($urandom_range(0, 5))
				0: curve[16*k +: 16] = 16'h7FFF - 16'($urandom_range(0, 3));
				1: curve[16*k +: 16] = 16'h8000 + 16'($urandom_range(0, 3));
				default: curve[16*k +: 16] = 16'($urandom);
			endcase
		end
		return curve;
	endfunction

	// Drop valid, wait for every predicted point, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// One-cycle register write; only called while the block is idle
	task automatic set_segments(input logic [cbpg_pkg::SEG_BITS-1:0] value);
		seg_wr_en   <= 1'b1;
		seg_wr_data <= value;
		@(posedge clk);
		seg_wr_en   <= 1'b0;
	endtask

	initial begin : curve_source
		logic [cbpg_pkg::SEG_BITS-1:0] seg;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed curves at the reset segment count of ten
		send_pattern(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_pattern(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_pattern(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_pattern(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_pattern(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_pattern(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_pattern(16'hFC18, 16'h0000, 16'h0000, 16'h03E8);
		send_pattern(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFE);
		send_pattern(16'h7FFE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_curve(random_curve());
		send_curve(random_curve());

		// Segment count zero acts as one: two points per curve
		settle();
		set_segments('0);
		send_pattern(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_curve(random_curve());
		send_curve(random_curve());

		settle();
		set_segments(6'd1);
		send_pattern(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send_curve(random_curve());

		// Largest count: 64 points per curve
		settle();
		set_segments(6'd63);
		send_pattern(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_curve(random_curve());

		settle();
		set_segments(6'd3);
		send_pattern(16'h7FFF, 16'h7FFE, 16'h7FFF, 16'h7FFF);
		send_pattern(16'h8001, 16'h8000, 16'h8000, 16'h8000);

		// Random curves: receiver idles more, then sender idles more, then neither.
		// The no-idle pass opens with the long receiver hold-off.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int chunk = 0; chunk < 4; chunk++) begin
				settle();
				case ($urandom_range(0, 7))
					0: seg = '0;
					1: seg = 6'd63;
					default: seg = 6'($urandom_range(1, 16));
				endcase
				set_segments(seg);
				if (mode == 2 && chunk == 0)
					hold_off_req = 1'b1;
				repeat (CHUNK_ITEMS) send_curve(random_curve());
			end
		end

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("cubic_bezier_point_generator regression: pass");
		end else begin
			$display("cubic_bezier_point_generator regression: fail");
		end
		$finish;
	end

endmodule
